// File: sv/rfbd_pkg.sv
// ----------------------------------------------------------------------------
// Request frame boundary detector package
// Shared types, codes and character constants for the framer and top level.
// ----------------------------------------------------------------------------
package rfbd_pkg;

    // Result field widths
    localparam int FRAME_LEN_BITS = 33;
    localparam int STATUS_BITS    = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int TYPE_BITS      = 32;

    // Saturation point of the byte counter
    localparam logic [FRAME_LEN_BITS-1:0] COUNT_MAX = '1;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_COMPLETE   = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_TYPE_ERROR = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PROTOCOL_MODE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_MESSAGE_TYPE = 2'd1;

    localparam logic [TYPE_BITS-1:0] MAX_TYPE_RESET = 32'd15;

    // Protocol modes
    localparam logic MODE_HTTP   = 1'b0;
    localparam logic MODE_BINARY = 1'b1;

    // Characters
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LOW_C = 8'h63;
    localparam logic [7:0] CASE_GAP   = 8'h20;

    // Length of "content-length:"
    localparam logic [3:0] KEY_LEN = 4'd15;

    // Framer control from the top level
    typedef struct packed {
        logic step;
        logic restart;
        logic protocol_mode;
    } framer_ctrl_t;

    // Framer result for the byte at the input register
    typedef struct packed {
        logic                      hit;
        logic [FRAME_LEN_BITS-1:0] length;
        logic [STATUS_BITS-1:0]    status;
    } frame_result_t;

    // Lowercase header key, one character per position
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            4'd14:   ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: sv/rfbd_framer.sv
// ----------------------------------------------------------------------------
// Request frame boundary framer
// Parse state and single-pass next-state logic for HTTP and binary framing.
// ----------------------------------------------------------------------------
module rfbd_framer
    import rfbd_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  framer_ctrl_t         ctrl,
    input  logic [7:0]           data_byte,
    input  logic [TYPE_BITS-1:0] max_message_type,
    output frame_result_t        result
);

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_VSKIP    = 3'd1,
        PH_DIGITS   = 3'd2,
        PH_BODY     = 3'd3,
        PH_BIN_BODY = 3'd5
    } phase_t;

    localparam logic [LENGTH_BITS-1:0] LEN_LIMIT = '1;
    localparam logic [31:0] LEN_LIMIT32 = 32'((64'd1 << LENGTH_BITS) - 64'd1);
    localparam logic [LENGTH_BITS+3:0] DIGIT_LIMIT =
        (LENGTH_BITS+4)'((64'd1 << LENGTH_BITS) - 64'd1);

    phase_t                    phase_reg, phase_next;
    logic [1:0]                blank_reg, blank_next;
    logic [3:0]                key_count_reg, key_count_next;
    logic                      length_seen_reg, length_seen_next;
    logic [LENGTH_BITS-1:0]    declared_reg, declared_next;
    logic [FRAME_LEN_BITS-1:0] bytes_reg, bytes_next;
    logic [55:0]               shift_reg, shift_next;
    logic [2:0]                index_reg, index_next;
    logic [LENGTH_BITS-1:0]    remaining_reg, remaining_next;
    logic [STATUS_BITS-1:0]    pending_reg, pending_next;

    logic                      hit;
    logic [7:0]                lc;
    logic                      is_digit;
    logic [LENGTH_BITS+3:0]    product;
    logic [31:0]               type_word;
    logic [31:0]               len_word;
    logic [LENGTH_BITS-1:0]    len_sat;

    always_comb
    begin
        phase_next       = phase_reg;
        blank_next       = blank_reg;
        key_count_next   = key_count_reg;
        length_seen_next = length_seen_reg;
        declared_next    = declared_reg;
        bytes_next       = bytes_reg;
        shift_next       = shift_reg;
        index_next       = index_reg;
        remaining_next   = remaining_reg;
        pending_next     = pending_reg;
        hit              = 1'b0;

        lc = (data_byte >= CHAR_UP_A && data_byte <= CHAR_UP_Z) ?
            data_byte + CASE_GAP : data_byte;
        is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
        product = ({4'b0000, declared_reg} << 3) + ({4'b0000, declared_reg} << 1)
                + (LENGTH_BITS+4)'(data_byte[3:0]);
        type_word = shift_reg[31:0];
        len_word  = {data_byte, shift_reg[55:32]};
        len_sat   = len_word[LENGTH_BITS-1:0];

        // Count every byte; saturate and flag at the top
        if (bytes_reg == COUNT_MAX)
        begin
            if (pending_next == STATUS_COMPLETE)
                pending_next = STATUS_OVERFLOW;
        end
        else
        begin
            bytes_next = bytes_reg + 1'b1;
        end

        if (phase_reg == PH_BODY || phase_reg == PH_BIN_BODY)
        begin
            remaining_next = remaining_reg - 1'b1;
            hit = (remaining_reg == LENGTH_BITS'(1));
        end
        else if (ctrl.protocol_mode == MODE_HTTP)
        begin
            if (phase_reg == PH_VSKIP)
            begin
                if (is_digit)
                begin
                    declared_next = LENGTH_BITS'(data_byte[3:0]);
                    phase_next    = PH_DIGITS;
                end
                else if (data_byte != CHAR_SPACE)
                begin
                    phase_next = PH_HEADER;
                end
            end
            else if (phase_reg == PH_DIGITS)
            begin
                if (is_digit)
                begin
                    if (product > DIGIT_LIMIT)
                    begin
                        declared_next = LEN_LIMIT;
                        if (pending_next == STATUS_COMPLETE)
                            pending_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        declared_next = product[LENGTH_BITS-1:0];
                    end
                end
                else
                begin
                    phase_next = PH_HEADER;
                end
            end
            else if (!length_seen_reg)
            begin
                if (key_count_reg < KEY_LEN && lc == key_char(key_count_reg))
                begin
                    if (key_count_reg == KEY_LEN - 4'd1)
                    begin
                        length_seen_next = 1'b1;
                        key_count_next   = 4'd0;
                        phase_next       = PH_VSKIP;
                    end
                    else
                    begin
                        key_count_next = key_count_reg + 4'd1;
                    end
                end
                else
                begin
                    key_count_next = (lc == CHAR_LOW_C) ? 4'd1 : 4'd0;
                end
            end

            // Track CR LF CR LF
            if (data_byte == CHAR_CR)
            begin
                blank_next = (blank_reg == 2'd2) ? 2'd3 : 2'd1;
            end
            else if (data_byte == CHAR_LF && blank_reg == 2'd1)
            begin
                blank_next = 2'd2;
            end
            else if (data_byte == CHAR_LF && blank_reg == 2'd3)
            begin
                blank_next = 2'd0;
                if (declared_next == '0)
                begin
                    hit = 1'b1;
                end
                else
                begin
                    phase_next     = PH_BODY;
                    remaining_next = declared_next;
                end
            end
            else
            begin
                blank_next = 2'd0;
            end
        end
        else
        begin
            // Binary header: collect seven bytes, decode on the eighth
            if (index_reg != 3'd7)
            begin
                shift_next[{index_reg, 3'b000} +: 8] = data_byte;
                index_next = index_reg + 3'd1;
            end
            else
            begin
                shift_next = '0;
                index_next = 3'd0;
                if (len_word > LEN_LIMIT32)
                begin
                    len_sat = LEN_LIMIT;
                    if (pending_next == STATUS_COMPLETE)
                        pending_next = STATUS_OVERFLOW;
                end
                if (type_word > max_message_type)
                    pending_next = STATUS_TYPE_ERROR;
                if (len_sat == '0)
                begin
                    hit              = (pending_next != STATUS_COMPLETE);
                    phase_next       = PH_HEADER;
                    blank_next       = 2'd0;
                    key_count_next   = 4'd0;
                    length_seen_next = 1'b0;
                    declared_next    = '0;
                    bytes_next       = hit ? bytes_next : '0;
                    remaining_next   = '0;
                    pending_next     = hit ? pending_next : STATUS_COMPLETE;
                end
                else
                begin
                    phase_next     = PH_BIN_BODY;
                    remaining_next = len_sat;
                end
            end
        end
    end

    assign result.hit    = hit;
    assign result.length = bytes_next;
    assign result.status = pending_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            blank_reg       <= 2'd0;
            key_count_reg   <= 4'd0;
            length_seen_reg <= 1'b0;
            declared_reg    <= '0;
            bytes_reg       <= '0;
            shift_reg       <= '0;
            index_reg       <= 3'd0;
            remaining_reg   <= '0;
            pending_reg     <= STATUS_COMPLETE;
        end
        else if (ctrl.restart || (ctrl.step && hit))
        begin
            // On restart or a finished message, drop the parse state and start over
            phase_reg       <= PH_HEADER;
            blank_reg       <= 2'd0;
            key_count_reg   <= 4'd0;
            length_seen_reg <= 1'b0;
            declared_reg    <= '0;
            bytes_reg       <= '0;
            shift_reg       <= '0;
            index_reg       <= 3'd0;
            remaining_reg   <= '0;
            pending_reg     <= STATUS_COMPLETE;
        end
        else if (ctrl.step)
        begin
            phase_reg       <= phase_next;
            blank_reg       <= blank_next;
            key_count_reg   <= key_count_next;
            length_seen_reg <= length_seen_next;
            declared_reg    <= declared_next;
            bytes_reg       <= bytes_next;
            shift_reg       <= shift_next;
            index_reg       <= index_next;
            remaining_reg   <= remaining_next;
            pending_reg     <= pending_next;
        end
    end

    a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY || phase_reg == PH_BIN_BODY) |-> (remaining_reg != '0))
        else $error("body phase with no bytes remaining");

    a_index_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        (index_reg != 3'd0) |-> (phase_reg == PH_HEADER))
        else $error("binary header index outside header phase");

    a_key_bound: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg < KEY_LEN)
        else $error("key match count past key length");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.restart |=> (bytes_reg == '0 && phase_reg == PH_HEADER))
        else $error("mode write did not restart parsing");

endmodule

// File: sv/request_frame_boundary_detector.sv
// ----------------------------------------------------------------------------
// Request frame boundary detector
// Frames a byte stream into HTTP or binary length-prefixed messages.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, data_byte) carries one stream byte per
//   transaction. Output channel (out_valid, out_stall, frame_length,
//   frame_status) carries one transaction per completed message: its total
//   byte count and a status (complete, binary type error, length overflow).
//   Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
//   protocol_mode at index 0 (any write restarts parsing) and
//   max_message_type at index 1; cfg_ready is always high and writes are
//   expected only while the block is idle.
// Timing:
//   One byte per cycle unless a finishing byte meets a stalled output. A byte
//   is held in the input register, is parsed there in a single pass, and its
//   result is registered in the output register, which drives out_valid.
// Reset clears all parse state, selects HTTP mode and sets
// max_message_type to 15. When the receiver stalls, the result holds in the
// output register; bytes that finish no message keep flowing, and a byte that
// would finish one holds the input register, which then stalls the sender.
// ----------------------------------------------------------------------------
module request_frame_boundary_detector
    import rfbd_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                data_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [FRAME_LEN_BITS-1:0] frame_length,
    output logic [STATUS_BITS-1:0]    frame_status,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // Configuration registers
    logic                 mode_reg;
    logic [TYPE_BITS-1:0] max_type_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Output register
    logic                      out_valid_reg;
    logic [FRAME_LEN_BITS-1:0] out_length_reg;
    logic [STATUS_BITS-1:0]    out_status_reg;

    logic          cfg_write;
    logic          restart;
    logic          fire;
    logic          in_take;
    framer_ctrl_t  ctrl;
    frame_result_t result;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign restart   = cfg_write && (cfg_index == CFG_PROTOCOL_MODE);

    // Advance the held byte unless it finishes a message and the output
    // register is full and stalled
    assign fire     = in_valid_reg && (!result.hit || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    assign ctrl.step          = fire;
    assign ctrl.restart       = restart;
    assign ctrl.protocol_mode = mode_reg;

    rfbd_framer #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_framer (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .data_byte        (in_byte_reg),
        .max_message_type (max_type_reg),
        .result           (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_HTTP;
            max_type_reg <= MAX_TYPE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PROTOCOL_MODE:    mode_reg     <= cfg_data[0];
                CFG_MAX_MESSAGE_TYPE: max_type_reg <= cfg_data[TYPE_BITS-1:0];
                default:              ; // unknown index: drop the write
            endcase
        end
    end

    // Input register: load on each input transaction, empty when parsed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= data_byte;
    end

    // Output register: hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && result.hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && result.hit)
        begin
            out_length_reg <= result.length;
            out_status_reg <= result.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_length = out_length_reg;
    assign frame_status = out_status_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && result.hit && out_valid_reg && out_stall))
        else $error("result overwrote a stalled output");

    a_fire_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> in_valid_reg)
        else $error("framer stepped without a held byte");

    a_stall_means_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (result.hit && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

endmodule

// File: sim/tb_request_frame_boundary_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Request frame boundary detector testbench
// Streams HTTP and binary length-prefixed requests one byte per transaction,
// predicts every frame boundary in a behavioral framer of its own, and checks
// each output transaction field by field. Sender gaps, receiver stalls and
// register writes between phases are all randomized.
// ----------------------------------------------------------------------------
module tb_request_frame_boundary_detector;
    import rfbd_pkg::*;

    localparam int LENGTH_BITS   = 32;
    localparam logic [35:0] LEN_LIMIT = (36'd1 << LENGTH_BITS) - 36'd1;
    localparam int ITEM_TARGET   = 1100;
    localparam int SETTLE_CYCLES = 4;     // covers the input and output registers
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 400000;

    // Parse phases of the behavioral framer
    typedef enum logic [2:0] {
        P_HEADER,
        P_VALUE_SKIP,
        P_DIGITS,
        P_BODY,
        P_BIN_BODY
    } parse_phase_t;

    // One completed frame as seen on the output channel
    typedef struct packed {
        logic [FRAME_LEN_BITS-1:0] len;
        logic [STATUS_BITS-1:0]    st;
    } frame_t;

    localparam frame_t NO_FRAME = '0;

    // One row of the directed table: an optional register write, then one
    // message (header text in HTTP mode, type and length words in binary
    // mode) and its body. Rows with a typed frame carry their own expectation.
    typedef struct {
        logic                      cfg_en;
        logic [CFG_INDEX_BITS-1:0] cfg_idx;
        logic [CFG_DATA_BITS-1:0]  cfg_val;
        string                     text;
        logic [31:0]               msg_type;
        logic [31:0]               msg_len;
        int                        body;
        logic                      typed;
        frame_t                    want;
    } case_row_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic [7:0]                data_byte = 8'h00;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [FRAME_LEN_BITS-1:0] frame_length;
    logic [STATUS_BITS-1:0]    frame_status;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    request_frame_boundary_detector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_length (frame_length),
        .frame_status (frame_status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Behavioral framer: configuration and per-message parse state
    // ------------------------------------------------------------------
    logic                      mode_q;
    logic [31:0]               max_type_q;
    parse_phase_t              phase;
    logic [1:0]                crlf_cnt;
    logic [3:0]                key_cnt;
    logic                      len_seen;
    logic [31:0]               decl_len;
    logic [FRAME_LEN_BITS-1:0] byte_cnt;
    logic [63:0]               hdr_bytes;
    logic [2:0]                hdr_idx;
    logic [31:0]               body_left;
    logic [STATUS_BITS-1:0]    pend_status;

    string key_text = "content-length:";

    frame_t expected_frames[$];
    int     error_count        = 0;
    int     item_count         = 0;
    int     burst_left         = 0;
    bit     table_result_given = 1'b0;
    int     cycle_count        = 0;
    int     stall_span         = 0;
    int     stall_style        = 0;

    function automatic void restart_message();
        phase       = P_HEADER;
        crlf_cnt    = '0;
        key_cnt     = '0;
        len_seen    = 1'b0;
        decl_len    = '0;
        byte_cnt    = '0;
        hdr_bytes   = '0;
        hdr_idx     = '0;
        body_left   = '0;
        pend_status = STATUS_COMPLETE;
    endfunction

    // Overflow only reports when nothing worse is pending
    function automatic void note_overflow();
        if (pend_status == STATUS_COMPLETE)
            pend_status = STATUS_OVERFLOW;
    endfunction

    function automatic frame_t close_message();
        frame_t res;
        res.len = byte_cnt;
        res.st  = pend_status;
        restart_message();
        return res;
    endfunction

    // Advance the framer by one stream byte; return 1 when it ends a frame
    function automatic bit frame_next_byte(input logic [7:0] b, output frame_t res);
        logic [7:0]  lc;
        bit          is_digit;
        logic [35:0] acc;
        logic [31:0] type_word;
        logic [35:0] len_word;
        res      = NO_FRAME;
        lc       = (b >= CHAR_UP_A && b <= CHAR_UP_Z) ? b + CASE_GAP : b;
        is_digit = (b >= CHAR_ZERO && b <= CHAR_NINE);

        // The byte counter saturates rather than wraps
        if (byte_cnt == COUNT_MAX)
            note_overflow();
        else
            byte_cnt = byte_cnt + 1'b1;

        if (mode_q == MODE_BINARY)
        begin
            if (phase == P_BIN_BODY)
            begin
                body_left = body_left - 1'b1;
                if (body_left == 0)
                begin
                    res = close_message();
                    return 1'b1;
                end
                return 1'b0;
            end
            hdr_bytes[8*hdr_idx +: 8] = b;
            hdr_idx = hdr_idx + 1'b1;
            if (hdr_idx != 0)
                return 1'b0;
            type_word = hdr_bytes[31:0];
            len_word  = {4'b0, hdr_bytes[63:32]};
            hdr_bytes = '0;
            if (len_word > LEN_LIMIT)
            begin
                len_word = LEN_LIMIT;
                note_overflow();
            end
            if (type_word > max_type_q)
                pend_status = STATUS_TYPE_ERROR;
            if (len_word == 0)
            begin
                // Good empty messages vanish; flagged ones still report
                if (pend_status != STATUS_COMPLETE)
                begin
                    res = close_message();
                    return 1'b1;
                end
                restart_message();
                return 1'b0;
            end
            phase     = P_BIN_BODY;
            body_left = len_word[31:0];
            return 1'b0;
        end

        if (phase == P_BODY)
        begin
            body_left = body_left - 1'b1;
            if (body_left == 0)
            begin
                res = close_message();
                return 1'b1;
            end
            return 1'b0;
        end

        case (phase)
            P_VALUE_SKIP:
            begin
                if (is_digit)
                begin
                    decl_len = 32'(b - CHAR_ZERO);
                    phase    = P_DIGITS;
                end
                else if (b != CHAR_SPACE)
                begin
                    phase = P_HEADER;
                end
            end
            P_DIGITS:
            begin
                if (is_digit)
                begin
                    acc = {4'b0, decl_len} * 36'd10 + 36'(b - CHAR_ZERO);
                    if (acc > LEN_LIMIT)
                    begin
                        acc = LEN_LIMIT;
                        note_overflow();
                    end
                    decl_len = acc[31:0];
                end
                else
                begin
                    phase = P_HEADER;
                end
            end
            default:
            begin
                // Only the first key counts; a repeated one is ignored
                if (!len_seen)
                begin
                    if (key_cnt < KEY_LEN && lc == key_text[key_cnt])
                    begin
                        key_cnt = key_cnt + 1'b1;
                        if (key_cnt == KEY_LEN)
                        begin
                            len_seen = 1'b1;
                            key_cnt  = '0;
                            phase    = P_VALUE_SKIP;
                        end
                    end
                    else
                    begin
                        key_cnt = (lc == CHAR_LOW_C) ? 4'd1 : 4'd0;
                    end
                end
            end
        endcase

        // Blank line tracking runs in every header phase
        if (b == CHAR_CR)
        begin
            crlf_cnt = (crlf_cnt == 2'd2) ? 2'd3 : 2'd1;
        end
        else if (b == CHAR_LF && crlf_cnt == 2'd1)
        begin
            crlf_cnt = 2'd2;
        end
        else if (b == CHAR_LF && crlf_cnt == 2'd3)
        begin
            crlf_cnt = 2'd0;
            if (decl_len == 0)
            begin
                res = close_message();
                return 1'b1;
            end
            phase     = P_BODY;
            body_left = decl_len;
        end
        else
        begin
            crlf_cnt = 2'd0;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Input side: bursts of transactions separated by random gaps
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        bit     stalled;
        int     gap;
        frame_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        data_byte <= b;
        // Sample stall at the falling edge, where it is settled for the next edge
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        item_count++;
        if (frame_next_byte(b, res) && !table_result_given)
            expected_frames.push_back(res);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            push_byte(s[k]);
    endtask

    // Binary header: little-endian type word, then little-endian length word
    task automatic send_header(input logic [31:0] msg_type, input logic [31:0] msg_len);
        for (int k = 0; k < 4; k++)
            push_byte(msg_type[8*k +: 8]);
        for (int k = 0; k < 4; k++)
            push_byte(msg_len[8*k +: 8]);
    endtask

    // Write a register once the block has gone quiet
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        bit ready_seen;
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        // Let a byte that ends no frame drain out of the pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            ready_seen = cfg_ready;
            @(posedge clk);
        end
        while (!ready_seen);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PROTOCOL_MODE:
            begin
                mode_q = val[0];
                restart_message();
            end
            CFG_MAX_MESSAGE_TYPE:
            begin
                max_type_q = val;
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Output side: the receiver stalls in spans of changing density
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_style <= $urandom_range(0, 3);
            stall_span  <= $urandom_range(20, 200);
        end
        else
        begin
            stall_span <= stall_span - 1;
        end
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Check each output transaction against the oldest expected frame.
    // Valid and stall are settled at the falling edge and hold to the next rise.
    always @(negedge clk)
    begin : check_frames
        frame_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_frames.size() == 0)
            begin
                $error("unexpected frame: frame_length %0d frame_status %0d",
                       frame_length, frame_status);
                error_count++;
            end
            else
            begin
                want = expected_frames.pop_front();
                if (frame_length !== want.len)
                begin
                    $error("frame_length: expected %0d, got %0d", want.len, frame_length);
                    error_count++;
                end
                if (frame_status !== want.st)
                begin
                    $error("frame_status: expected %0d, got %0d", want.st, frame_status);
                    error_count++;
                end
            end
        end
    end

    // Hard stop for a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table: edges of every field, each flagged case, every register
    // ------------------------------------------------------------------
    case_row_t dir_cases [17] = '{
        // Bare blank line: no key, no body
        '{1'b0, CFG_PROTOCOL_MODE, 32'h0, "\r\n\r\n", 32'h0, 32'h0, 0,
          1'b1, {33'd4, STATUS_COMPLETE}},
        '{1'b0, CFG_PROTOCOL_MODE, 32'h0, "Content-Length: 3\r\n\r\n", 32'h0, 32'h0, 3,
          1'b0, NO_FRAME},
        // Key followed by no digits
        '{1'b0, CFG_PROTOCOL_MODE, 32'h0, "content-length:x\r\nHost: a\r\n\r\n",
          32'h0, 32'h0, 0, 1'b0, NO_FRAME},
        // Repeated key, second one ignored
        '{1'b0, CFG_PROTOCOL_MODE, 32'h0,
          "CONTENT-LENGTH:  2\r\ncontent-length: 9\r\n\r\n", 32'h0, 32'h0, 2,
          1'b0, NO_FRAME},
        // Restarted key match, digits stop at the space
        '{1'b0, CFG_PROTOCOL_MODE, 32'h0, "ccontent-length:1 7\r\n\r\n", 32'h0, 32'h0, 1,
          1'b0, NO_FRAME},
        // Saturating length: the body never completes, the next mode write drops it
        '{1'b0, CFG_PROTOCOL_MODE, 32'h0, "content-length: 99999999999\r\n\r\n",
          32'h0, 32'h0, 5, 1'b0, NO_FRAME},
        '{1'b1, CFG_PROTOCOL_MODE, 32'hFFFF_FFFF, "", 32'h0, 32'd4, 4,
          1'b1, {33'd12, STATUS_COMPLETE}},
        // Good empty binary message vanishes
        '{1'b0, CFG_PROTOCOL_MODE, 32'h0, "", 32'd15, 32'd0, 0, 1'b0, NO_FRAME},
        // Bad type with zero length reports at once
        '{1'b0, CFG_PROTOCOL_MODE, 32'h0, "", 32'hFFFF_FFFF, 32'd0, 0,
          1'b1, {33'd8, STATUS_TYPE_ERROR}},
        '{1'b0, CFG_PROTOCOL_MODE, 32'h0, "", 32'd16, 32'd2, 2,
          1'b1, {33'd10, STATUS_TYPE_ERROR}},
        // Largest length word: abandoned by the next mode write
        '{1'b0, CFG_PROTOCOL_MODE, 32'h0, "", 32'h0, 32'hFFFF_FFFF, 3, 1'b0, NO_FRAME},
        '{1'b1, CFG_PROTOCOL_MODE, 32'd1, "", 32'hFFFF_FFFF, 32'd1, 1,
          1'b1, {33'd9, STATUS_TYPE_ERROR}},
        '{1'b1, CFG_MAX_MESSAGE_TYPE, 32'hFFFF_FFFF, "", 32'hFFFF_FFFF, 32'd1, 1,
          1'b1, {33'd9, STATUS_COMPLETE}},
        '{1'b1, CFG_MAX_MESSAGE_TYPE, 32'h0, "", 32'd1, 32'd0, 0,
          1'b1, {33'd8, STATUS_TYPE_ERROR}},
        // Unused register indexes change nothing
        '{1'b1, 2'd2, 32'hFFFF_FFFF, "", 32'h0, 32'd0, 0, 1'b0, NO_FRAME},
        '{1'b1, 2'd3, 32'h0, "", 32'h0, 32'd1, 1, 1'b1, {33'd9, STATUS_COMPLETE}},
        // Only bit 0 of the mode word counts
        '{1'b1, CFG_PROTOCOL_MODE, 32'hFFFF_FFFE, "X: 0\r\nContent-length:0\r\n\r\n",
          32'h0, 32'h0, 0, 1'b0, NO_FRAME}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int          msg_total;
        int          body_len;
        int          pick;
        logic [31:0] mtype;
        logic [31:0] mlen;
        logic [7:0]  ch;

        mode_q     = MODE_HTTP;
        max_type_q = MAX_TYPE_RESET;
        restart_message();

        // Hold reset, then release it for good
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_cases[i])
        begin
            if (dir_cases[i].cfg_en)
                write_reg(dir_cases[i].cfg_idx, dir_cases[i].cfg_val);
            table_result_given = dir_cases[i].typed;
            if (dir_cases[i].typed)
                expected_frames.push_back(dir_cases[i].want);
            if (mode_q == MODE_BINARY)
                send_header(dir_cases[i].msg_type, dir_cases[i].msg_len);
            else
                send_text(dir_cases[i].text);
            repeat (dir_cases[i].body) push_byte(8'($urandom_range(0, 255)));
            table_result_given = 1'b0;
        end

        // Random phases: each opens with a mode write, which also drops any
        // broken message left by the phase before
        while (item_count < ITEM_TARGET)
        begin
            write_reg(CFG_PROTOCOL_MODE, $urandom);
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_INDEX_BITS'($urandom_range(2, 3)), $urandom);
            if (mode_q == MODE_BINARY && $urandom_range(0, 1))
            begin
                case ($urandom_range(0, 3))
                    0:       write_reg(CFG_MAX_MESSAGE_TYPE, 32'h0);
                    1:       write_reg(CFG_MAX_MESSAGE_TYPE, 32'hFFFF_FFFF);
                    2:       write_reg(CFG_MAX_MESSAGE_TYPE, $urandom_range(0, 20));
                    default: write_reg(CFG_MAX_MESSAGE_TYPE, $urandom);
                endcase
            end

            msg_total = $urandom_range(3, 12);
            repeat (msg_total)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // Raw noise between messages
                    repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(0, 255)));
                end
                else if (mode_q == MODE_BINARY)
                begin
                    mtype = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 20);
                    pick  = $urandom_range(0, 19);
                    if (pick < 4)
                        mlen = 32'd0;
                    else if (pick == 19)
                        mlen = $urandom_range(17, 80);
                    else
                        mlen = $urandom_range(1, 16);
                    send_header(mtype, mlen);
                    repeat (mlen) push_byte(8'($urandom_range(0, 255)));
                end
                else
                begin
                    body_len = 0;
                    if ($urandom_range(0, 1))
                        send_text($sformatf("GET /%0d HTTP/1.1\r\n", $urandom_range(0, 999)));
                    // Filler lines; some carry a partial key or raw bytes
                    repeat ($urandom_range(0, 2))
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            repeat ($urandom_range(1, 8))
                                push_byte(8'($urandom_range(0, 255)));
                            send_text("\r\n");
                        end
                        else
                        begin
                            send_text($sformatf("X-%0d: conte%0d\r\n",
                                                $urandom_range(0, 99), $urandom_range(0, 99)));
                        end
                    end
                    if ($urandom_range(0, 3) != 0)
                    begin
                        // Key in mixed case
                        for (int k = 0; k < KEY_LEN; k++)
                        begin
                            ch = key_text[k];
                            if (ch >= "a" && ch <= "z" && $urandom_range(0, 1))
                                ch = ch - CASE_GAP;
                            push_byte(ch);
                        end
                        repeat ($urandom_range(0, 2)) push_byte(CHAR_SPACE);
                        case ($urandom_range(0, 7))
                            0:
                            begin
                                send_text("none");
                            end
                            1:
                            begin
                                body_len = $urandom_range(0, 400);
                                send_text($sformatf("%0d", body_len));
                            end
                            2:
                            begin
                                body_len = $urandom_range(0, 24);
                                send_text($sformatf("00%0d", body_len));
                            end
                            default:
                            begin
                                body_len = $urandom_range(0, 24);
                                send_text($sformatf("%0d", body_len));
                            end
                        endcase
                        send_text("\r\n");
                        if ($urandom_range(0, 4) == 0)
                            send_text("Content-Length: 77\r\n");
                    end
                    send_text("\r\n");
                    repeat (body_len) push_byte(8'($urandom_range(0, 255)));
                end
            end

            // Leave a broken message behind now and then
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
        end

        // Drop valid and drain every outstanding frame
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
